// ===== rtl/core/amm_pkg.sv =====
package amm_pkg;

  localparam int unsigned NumInputs  = 4;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned GainBits   = 9;
  localparam int unsigned AccBits    = 27;
  localparam int unsigned MixBits    = 25;
  localparam int unsigned MulABits   = 34;
  localparam int unsigned MulBBits   = 17;
  localparam int unsigned MulPBits   = MulABits + MulBBits;
  localparam int unsigned MulCntBits = 5;
  localparam int unsigned OutBits    = 18;

  localparam logic [2:0] RegGains  = 3'd0;
  localparam logic [2:0] RegRoute  = 3'd1;
  localparam logic [2:0] RegMaster = 3'd2;
  localparam logic [2:0] RegBal    = 3'd3;
  localparam logic [2:0] RegMono   = 3'd4;
  localparam logic [2:0] RegMute   = 3'd5;
  localparam logic [2:0] RegDc     = 3'd6;

  localparam logic [35:0] GainsReset  = 36'h804020100;
  localparam logic [7:0]  RouteReset  = 8'hFF;
  localparam logic [8:0]  MasterReset = 9'd256;

  localparam logic [0:0] OpWrite = 1'b0;
  localparam logic [0:0] OpTick  = 1'b1;

  typedef struct packed {
    logic [35:0] input_gains;
    logic [7:0]  route_mask;
    logic [8:0]  master_volume;
    logic [9:0]  balance;
    logic        mono_enable;
    logic        mute_enable;
    logic [15:0] dc_offset;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Saturates a signed 21-bit difference to the signed 18-bit output range.
  function automatic logic [OutBits-1:0] sat_out(input logic signed [20:0] r);
    logic [OutBits-1:0] res;
    if (r > 21'sd131071) begin
      res = 18'h1FFFF;
    end else if (r < -21'sd131072) begin
      res = 18'h20000;
    end else begin
      res = r[OutBits-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/audio_matrix_mixer.sv =====
// A sample write returns nothing; the next word is taken at once.
// A tick reopens the input in the same cycle as its result turns valid: the
// shared bit-serial multiplier handles four 9-bit gain products, then per output master
// (9), balance volume (9) and DC scale (17), one product at a time.
// One tick result may wait in the output register while the next words are taken.
// Reset (rst_ni, asynchronous, active low) loads register defaults and clears the samples.
module audio_matrix_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  input  logic [2:0]  s_axis_tuser,   // opcode, channel[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // left_sample[17:0], right_sample[35:18], zero fill
);

  amm_pkg::cfg_t cfg_q;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gains   <= amm_pkg::GainsReset;
      cfg_q.route_mask    <= amm_pkg::RouteReset;
      cfg_q.master_volume <= amm_pkg::MasterReset;
      cfg_q.balance       <= '0;
      cfg_q.mono_enable   <= 1'b0;
      cfg_q.mute_enable   <= 1'b0;
      cfg_q.dc_offset     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        amm_pkg::RegGains:  cfg_q.input_gains   <= pwdata[35:0];
        amm_pkg::RegRoute:  cfg_q.route_mask    <= pwdata[7:0];
        amm_pkg::RegMaster: cfg_q.master_volume <= pwdata[8:0];
        amm_pkg::RegBal:    cfg_q.balance       <= pwdata[9:0];
        amm_pkg::RegMono:   cfg_q.mono_enable   <= pwdata[0];
        amm_pkg::RegMute:   cfg_q.mute_enable   <= pwdata[0];
        amm_pkg::RegDc:     cfg_q.dc_offset     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      amm_pkg::RegGains:  prdata = 64'(cfg_q.input_gains);
      amm_pkg::RegRoute:  prdata = 64'(cfg_q.route_mask);
      amm_pkg::RegMaster: prdata = 64'(cfg_q.master_volume);
      amm_pkg::RegBal:    prdata = 64'(cfg_q.balance);
      amm_pkg::RegMono:   prdata = 64'(cfg_q.mono_enable);
      amm_pkg::RegMute:   prdata = 64'(cfg_q.mute_enable);
      amm_pkg::RegDc:     prdata = 64'(cfg_q.dc_offset);
      default:            prdata = '0;
    endcase
  end

  amm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/amm_smul.sv =====
module amm_smul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [amm_pkg::MulABits-1:0]    a_i,
  input  logic [amm_pkg::MulBBits-1:0]    b_i,
  input  logic [amm_pkg::MulCntBits-1:0]  nbits_i,
  output amm_pkg::mul_stat_t              stat_o,
  output logic [amm_pkg::MulPBits-1:0]    prod_o
);

  logic [amm_pkg::MulPBits-1:0]   a_q;
  logic [amm_pkg::MulBBits-1:0]   b_q;
  logic [amm_pkg::MulPBits-1:0]   p_q;
  logic [amm_pkg::MulCntBits-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // One multiplier bit per cycle: add the shifted multiplicand when it is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= {{amm_pkg::MulBBits{1'b0}}, a_i};
        b_q    <= b_i;
        p_q    <= '0;
        cnt_q  <= nbits_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (b_q[0]) begin
          p_q <= p_q + a_q;
        end
        a_q   <= {a_q[amm_pkg::MulPBits-2:0], 1'b0};
        b_q   <= {1'b0, b_q[amm_pkg::MulBBits-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == amm_pkg::MulCntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = p_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiply started while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while still busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (nbits_i != '0) |=> busy_q) else $error("multiply did not start");

endmodule

// ===== rtl/core/amm_core.sv =====
module amm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amm_pkg::cfg_t       cfg_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // sample
  input  logic [2:0]          s_axis_tuser,   // opcode, channel[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata    // left_sample, right_sample, zero fill
);

  typedef enum logic [2:0] {
    StIdle, StGain, StMix, StMast, StVol, StDcs, StEmit
  } state_e;

  state_e state_q;
  logic [amm_pkg::SampleBits-1:0] held_q [amm_pkg::NumInputs];
  logic [1:0]                     j_q;
  logic                           o_q;
  logic [amm_pkg::AccBits-1:0]    accl_q, accr_q;
  logic [amm_pkg::MixBits-1:0]    mixr_q;
  logic [amm_pkg::OutBits-1:0]    resl_q, resr_q, left_q, right_q;
  logic                           mvalid_q;
  logic                           start_q;
  logic [amm_pkg::MulABits-1:0]   op_a_q;
  logic [amm_pkg::MulBBits-1:0]   op_b_q;
  logic [amm_pkg::MulCntBits-1:0] op_n_q;

  amm_pkg::mul_stat_t           mstat;
  logic [amm_pkg::MulPBits-1:0] prod;

  amm_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .nbits_i (op_n_q),
    .stat_o  (mstat),
    .prod_o  (prod)
  );

  logic                          accept;
  logic [8:0]                    vol_l, vol_r, vol_sel;
  logic [amm_pkg::MixBits-1:0]   mix_l, mix_r, ml, mr;
  logic [amm_pkg::MixBits:0]     mix_sum;
  logic signed [9:0]             bal;
  logic [19:0]                   u_val;
  logic signed [20:0]            diff;
  logic [amm_pkg::OutBits-1:0]   res_now;

  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mix_l   = accl_q[amm_pkg::AccBits-1:2];
    mix_r   = accr_q[amm_pkg::AccBits-1:2];
    mix_sum = {1'b0, mix_l} + {1'b0, mix_r};
    if (cfg_i.mute_enable) begin
      ml = '0;
      mr = '0;
    end else if (cfg_i.mono_enable) begin
      ml = mix_sum[amm_pkg::MixBits:1];
      mr = mix_sum[amm_pkg::MixBits:1];
    end else begin
      ml = mix_l;
      mr = mix_r;
    end
  end

  // The balance register spans 10 bits, so it is clamped to plus or minus unity.
  always_comb begin
    bal = $signed(cfg_i.balance);
    if (bal < -10'sd256) bal = -10'sd256;
    if (bal > 10'sd256)  bal = 10'sd256;
    if (bal <= 10'sd0) begin
      vol_l = 9'd256;
      vol_r = 9'(10'sd256 + bal);
    end else begin
      vol_l = 9'(10'sd256 - bal);
      vol_r = 9'd256;
    end
    vol_sel = o_q ? vol_r : vol_l;
  end

  assign u_val   = prod[35:16];
  assign diff    = $signed({1'b0, u_val}) - $signed({5'b0, cfg_i.dc_offset});
  assign res_now = amm_pkg::sat_out(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mvalid_q <= 1'b0;
      start_q  <= 1'b0;
      j_q      <= '0;
      o_q      <= 1'b0;
      for (int i = 0; i < amm_pkg::NumInputs; i++) held_q[i] <= '0;
    end else begin
      start_q <= 1'b0;
      if (mvalid_q && m_axis_tready && state_q != StEmit) mvalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (s_axis_tuser[0] == amm_pkg::OpWrite) begin
              held_q[s_axis_tuser[2:1]] <= s_axis_tdata;
            end else begin
              accl_q  <= '0;
              accr_q  <= '0;
              j_q     <= '0;
              o_q     <= 1'b0;
              op_a_q  <= amm_pkg::MulABits'(held_q[0]);
              op_b_q  <= amm_pkg::MulBBits'(cfg_i.input_gains[8:0]);
              op_n_q  <= amm_pkg::MulCntBits'(amm_pkg::GainBits);
              start_q <= 1'b1;
              state_q <= StGain;
            end
          end
        end
        StGain: begin
          if (mstat.done) begin
            if (cfg_i.route_mask[{1'b0, j_q}]) begin
              accl_q <= accl_q + amm_pkg::AccBits'(prod[24:0]);
            end
            if (cfg_i.route_mask[{1'b1, j_q}]) begin
              accr_q <= accr_q + amm_pkg::AccBits'(prod[24:0]);
            end
            if (j_q == 2'd3) begin
              state_q <= StMix;
            end else begin
              j_q     <= j_q + 1'b1;
              op_a_q  <= amm_pkg::MulABits'(held_q[j_q + 1'b1]);
              op_b_q  <= amm_pkg::MulBBits'(cfg_i.input_gains[9*(j_q + 1'b1) +: 9]);
              start_q <= 1'b1;
            end
          end
        end
        StMix: begin
          mixr_q  <= mr;
          op_a_q  <= amm_pkg::MulABits'(ml);
          op_b_q  <= amm_pkg::MulBBits'(cfg_i.master_volume);
          op_n_q  <= amm_pkg::MulCntBits'(9);
          start_q <= 1'b1;
          state_q <= StMast;
        end
        StMast: begin
          if (mstat.done) begin
            op_a_q  <= prod[amm_pkg::MulABits-1:0];
            op_b_q  <= amm_pkg::MulBBits'(vol_sel);
            op_n_q  <= amm_pkg::MulCntBits'(9);
            start_q <= 1'b1;
            state_q <= StVol;
          end
        end
        StVol: begin
          if (mstat.done) begin
            op_a_q  <= amm_pkg::MulABits'(prod[42:24]);
            op_b_q  <= {1'b1, cfg_i.dc_offset};
            op_n_q  <= amm_pkg::MulCntBits'(amm_pkg::MulBBits);
            start_q <= 1'b1;
            state_q <= StDcs;
          end
        end
        StDcs: begin
          if (mstat.done) begin
            if (!o_q) begin
              resl_q  <= res_now;
              o_q     <= 1'b1;
              op_a_q  <= amm_pkg::MulABits'(mixr_q);
              op_b_q  <= amm_pkg::MulBBits'(cfg_i.master_volume);
              op_n_q  <= amm_pkg::MulCntBits'(9);
              start_q <= 1'b1;
              state_q <= StMast;
            end else begin
              resr_q  <= res_now;
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          // The output pair is only replaced once the earlier word has left.
          if (!mvalid_q || m_axis_tready) begin
            left_q   <= resl_q;
            right_q  <= resr_q;
            mvalid_q <= 1'b1;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {4'b0, right_q, left_q};

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser[0] == amm_pkg::OpTick) |=> start_q && state_q == StGain)
    else $error("tick did not start the mix");
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q) == StEmit) else $error("result without emit");
  a_no_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !mstat.busy) else $error("multiplier busy while idle");

endmodule

// ===== tb/tb_audio_matrix_mixer.sv =====
`timescale 1ns / 100ps

module tb_audio_matrix_mixer;

  typedef struct packed {
    logic [0:0]  op;
    logic [1:0]  chan;
    logic [15:0] smp;
  } mix_word_t;

  // One row of the directed table; has_exp marks rows whose result is typed in.
  typedef struct {
    mix_word_t                   word;
    bit                          has_exp;
    logic [amm_pkg::OutBits-1:0] exp_l;
    logic [amm_pkg::OutBits-1:0] exp_r;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // sample
  logic [2:0]  s_axis_tuser;    // opcode, channel[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;    // left_sample[17:0], right_sample[35:18], zero fill

  audio_matrix_mixer dut (.*);

  // Predictor state.
  amm_pkg::cfg_t cur_cfg;
  logic [15:0]   held [amm_pkg::NumInputs];
  logic [35:0]   mix_queue [$];
  int            err_count;
  bit            sink_stall_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [amm_pkg::OutBits-1:0] scale_chan(input longint unsigned mix,
                                                             input longint unsigned vol);
    longint unsigned t, u;
    longint r;
    t = (mix * cur_cfg.master_volume * vol) >> (amm_pkg::SampleBits + 8);
    u = (t * (65536 + cur_cfg.dc_offset)) >> 16;
    r = longint'(u) - longint'(cur_cfg.dc_offset);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[amm_pkg::OutBits-1:0];
  endfunction

  function automatic longint unsigned sum_out(input int o);
    longint unsigned acc;
    acc = 0;
    for (int j = 0; j < amm_pkg::NumInputs; j++) begin
      if (cur_cfg.route_mask[4*o+j])
        acc += longint'(cur_cfg.input_gains[9*j +: 9]) * held[j];
    end
    return acc / amm_pkg::NumInputs;
  endfunction

  // Returns 1 and the packed result when the word is a tick.
  function automatic bit mix_predict(input mix_word_t w, output logic [35:0] res);
    longint unsigned l, r, vl, vr;
    int bal;
    res = '0;
    if (w.op == amm_pkg::OpWrite) begin
      held[w.chan] = w.smp;
      return 0;
    end
    if (cur_cfg.mute_enable) begin
      l = 0;
      r = 0;
    end else begin
      l = sum_out(0);
      r = sum_out(1);
      if (cur_cfg.mono_enable) begin
        l = (l + r) >> 1;
        r = l;
      end
    end
    bal = int'($signed(cur_cfg.balance));
    if (bal < -256) bal = -256;
    if (bal > 256) bal = 256;
    if (bal <= 0) begin
      vl = 256;
      vr = 256 + bal;
    end else begin
      vl = 256 - bal;
      vr = 256;
    end
    res = {scale_chan(r, vr), scale_chan(l, vl)};
    return 1;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      amm_pkg::RegGains:  cur_cfg.input_gains   = val[35:0];
      amm_pkg::RegRoute:  cur_cfg.route_mask    = val[7:0];
      amm_pkg::RegMaster: cur_cfg.master_volume = val[8:0];
      amm_pkg::RegBal:    cur_cfg.balance       = val[9:0];
      amm_pkg::RegMono:   cur_cfg.mono_enable   = val[0];
      amm_pkg::RegMute:   cur_cfg.mute_enable   = val[0];
      amm_pkg::RegDc:     cur_cfg.dc_offset     = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic gap(input int long_pct);
    int n;
    if ($urandom_range(99) < long_pct) n = $urandom_range(40, 10);
    else n = $urandom_range(3, 1);
    repeat (n) @(posedge clk_i);
  endtask

  // Drives one word; the model is updated at the accepting edge.
  task automatic send_word(input mix_word_t w, input bit idle_on);
    logic [35:0] res;
    if (idle_on && $urandom_range(2) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap(5);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.smp;
    s_axis_tuser  <= {w.chan, w.op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (mix_predict(w, res)) mix_queue.push_back(res);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mix_queue.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic mix_word_t rand_word(input int tick_pct);
    mix_word_t w;
    w.op   = ($urandom_range(99) < tick_pct) ? amm_pkg::OpTick : amm_pkg::OpWrite;
    w.chan = 2'($urandom_range(3));
    case ($urandom_range(5))
      0: w.smp = 16'h0000;
      1: w.smp = 16'hFFFF;
      default: w.smp = 16'($urandom);
    endcase
    return w;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    logic [35:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mix_queue.size() == 0) begin
        report($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = mix_queue.pop_front();
        if (m_axis_tdata[17:0] !== want[17:0])
          report($sformatf("left got %h want %h", m_axis_tdata[17:0], want[17:0]));
        if (m_axis_tdata[35:18] !== want[35:18])
          report($sformatf("right got %h want %h", m_axis_tdata[35:18], want[35:18]));
      end
    end
  end

  // Sink backpressure.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!sink_stall_on) m_axis_tready <= 1'b1;
      else if ($urandom_range(99) < 3) m_axis_tready <= 1'b0;
      else if ($urandom_range(99) < 30) m_axis_tready <= 1'b1;
    end
  end

  initial begin
    dir_row_t    rows [$];
    dir_row_t    row;
    logic [35:0] res;
    int          ticks;

    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    sink_stall_on = 1'b0;
    err_count = 0;
    cur_cfg = '{input_gains: amm_pkg::GainsReset, route_mask: amm_pkg::RouteReset,
                master_volume: amm_pkg::MasterReset, default: '0};
    foreach (held[i]) held[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a tick right after reset sees cleared samples.
    rows.push_back('{'{amm_pkg::OpTick, 2'd0, 16'h0000}, 1'b1, 18'h0, 18'h0});
    for (int c = 0; c < 4; c++)
      rows.push_back('{'{amm_pkg::OpWrite, 2'(c), 16'hFFFF}, 1'b0, '0, '0});
    rows.push_back('{'{amm_pkg::OpTick, 2'd3, 16'hFFFF}, 1'b0, '0, '0});
    rows.push_back('{'{amm_pkg::OpWrite, 2'd2, 16'h0000}, 1'b0, '0, '0});
    rows.push_back('{'{amm_pkg::OpWrite, 2'd1, 16'h8000}, 1'b0, '0, '0});
    rows.push_back('{'{amm_pkg::OpTick, 2'd0, 16'h1234}, 1'b0, '0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_word(row.word, 1'b0);
      if (row.has_exp) begin
        res = mix_queue[$];
        if (res !== {row.exp_r, row.exp_l}) report("directed row mismatch");
      end
    end
    drain();

    // Extremes of the registers, then a tick under each.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: reg_write(amm_pkg::RegGains, 64'hF_FFFF_FFFF);
        1: reg_write(amm_pkg::RegMaster, 64'd511);
        2: reg_write(amm_pkg::RegBal, 64'h200);
        3: reg_write(amm_pkg::RegBal, 64'h1FF);
        4: reg_write(amm_pkg::RegDc, 64'hFFFF);
        5: reg_write(amm_pkg::RegMono, 64'd1);
        6: reg_write(amm_pkg::RegRoute, 64'h0F);
        7: reg_write(amm_pkg::RegMute, 64'd1);
        default: ;
      endcase
      send_word('{amm_pkg::OpTick, 2'd0, 16'h0}, 1'b0);
      drain();
    end

    // Random phases with random settings.
    sink_stall_on = 1'b1;
    ticks = 0;
    for (int ph = 0; ph < 15 || ticks < 60; ph++) begin
      reg_write(amm_pkg::RegGains, {$urandom, $urandom});
      reg_write(amm_pkg::RegRoute, 64'($urandom));
      reg_write(amm_pkg::RegMaster, (ph % 3 == 0) ? 64'd256 : 64'($urandom_range(511)));
      reg_write(amm_pkg::RegBal, (ph % 4 == 0) ? 64'($urandom_range(1023)) :
                64'(10'($urandom_range(512) - 256)));
      reg_write(amm_pkg::RegMono, 64'($urandom_range(1)));
      reg_write(amm_pkg::RegMute, 64'($urandom_range(9) == 0));
      reg_write(amm_pkg::RegDc, ($urandom_range(2) == 0) ? 64'd0 : 64'($urandom));
      for (int k = 0; k < 30; k++) begin
        mix_word_t w;
        w = rand_word(25);
        if (w.op == amm_pkg::OpTick) ticks++;
        send_word(w, 1'b1);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/amm_pkg.sv
rtl/core/amm_smul.sv
rtl/core/amm_core.sv
rtl/core/audio_matrix_mixer.sv
tb/tb_audio_matrix_mixer.sv
